/* rtl/core/prdac_pkg.sv */
// ----------------------------------------------------------------------------
// prdac_pkg
// shared types, constants and tables of the ring-fed psg attenuation dac
// ----------------------------------------------------------------------------
package prdac_pkg;

	// ring of samples, a power of two in 16..65536
	localparam int RING_DEPTH = 4096;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	// entries of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// field widths
	localparam int ADDR_W    = 12;
	localparam int SAMPLE_W  = 8;
	localparam int ELAPSED_W = 32;
	localparam int RATE_W    = 18;
	localparam int LEN_W     = 13;
	localparam int POS_W     = 12;
	localparam int WHOLE_W   = 13;
	localparam int FRAC_W    = 20;
	localparam int DUE_W     = 31;
	localparam int RING_W    = 25;
	localparam int LIN_W     = RING_W - 1;
	localparam int SUM_W     = 32;
	localparam int LEVEL_W   = 4;
	localparam int BYTE_W    = 8;

	// shared serial divider
	localparam int DIV_W  = 38;
	localparam int DSR_W  = 25;
	localparam int STEP_W = 6;

	// port widths
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 18;

	localparam logic [FRAC_W-1:0] US_PER_SEC    = 20'd1000000;
	localparam logic [RATE_W-1:0] RATE_RESET    = 18'd8000;
	localparam logic [LEN_W-1:0]  SEG_LEN_RESET = 13'd1024;
	localparam logic [LEN_W-1:0]  SEG_CNT_RESET = 13'd4;
	localparam logic [LEN_W-1:0]  LEN_MAX       = 13'd4096;
	localparam logic [BYTE_W-1:0] PSG_ATTEN_CMD = 8'h90;
	localparam logic [BYTE_W-1:0] DONE_MAX      = 8'd255;

	// item kinds
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_RATE = 4'd0,
		REG_SEG_LEN     = 4'd1,
		REG_SEG_CNT     = 4'd2,
		REG_ENABLE      = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                 func;
		logic [ADDR_W-1:0]    sample_address;
		logic [SAMPLE_W-1:0]  sample_value;
		logic [ELAPSED_W-1:0] elapsed_us;
	} op_t;

	typedef struct packed {
		logic [RATE_W-1:0] sample_rate;
		logic [LEN_W-1:0]  seg_len_raw;
		logic [LEN_W-1:0]  seg_len;
		logic [LEN_W-1:0]  seg_cnt;
		logic              enable;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DSR_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
		logic [DSR_W-1:0] rmd;
	} div_rsp_t;

	// attenuation levels, index 15 is silence
	localparam logic [0:15][11:0] ATTEN_LEVELS = '{
		12'h0ff0, 12'h0cb0, 12'h0a10, 12'h0800,
		12'h0650, 12'h0500, 12'h0400, 12'h0330,
		12'h0280, 12'h0200, 12'h0190, 12'h0140,
		12'h0100, 12'h00c0, 12'h00a0, 12'h0000
	};

	typedef logic [0:255][LEVEL_W-1:0] level_lut_t;

	// (s * 0xff0 + 127) / 255 is exactly 16 * s, so the target is s << 4;
	// nearest level, lowest index on a tie
	function automatic level_lut_t build_level_lut();
		level_lut_t  lut;
		logic [12:0] target;
		logic [12:0] lv;
		logic [12:0] err;
		logic [12:0] best_err;
		logic [3:0]  best;
		for (int s = 0; s < 256; s++) begin
			target   = 13'(s * 16);
			best     = 4'd15;
			best_err = '1;
			for (int i = 0; i < 16; i++) begin
				lv  = 13'(ATTEN_LEVELS[i]);
				err = (lv > target) ? (lv - target) : (target - lv);
				if (err < best_err) begin
					best_err = err;
					best     = 4'(i);
				end
			end
			lut[s] = best;
		end
		return lut;
	endfunction

	localparam level_lut_t LEVEL_LUT = build_level_lut();

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (v > LEN_MAX) begin
			r = LEN_MAX;
		end
		return r;
	endfunction

endpackage

/* rtl/core/pcm_ring_to_psg_attenuation_dac_top.sv */
// ----------------------------------------------------------------------------
// pcm_ring_to_psg_attenuation_dac_top
// sample ring played out as psg attenuation commands, paced by time ticks
// ----------------------------------------------------------------------------
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tuser: func; s_tdata: address, sample, elapsed_us
// m_*       out  m_tvalid/m_tready   m_tdata: psg_byte, segments_completed, position
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// the front takes one beat a cycle while its two-entry queue has room; the back
// stores a sample write as it pops it; for a tick it first does the time scaling
// by reciprocal multiplication, then four divisions on the shared radix-2 divider
// (100 quotient steps in all); a tick with no sample due ends after the scaling
// with no result
// a finished result waits in the output register while the back pulls the next
// item, so a stalled m_tready backs up into the queue and then s_tready
// reset is asynchronous and needs no clearing pass; ring entries are undefined
// until written
// ----------------------------------------------------------------------------
module pcm_ring_to_psg_attenuation_dac_top import prdac_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // sample_address, sample_value, elapsed_us, zero pad
	input  logic                  s_tuser,   // func
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // psg_byte, segments_completed,
	                                         // position_in_segment, zero pad
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [RATE_W-1:0] sample_rate_q;
	logic [LEN_W-1:0]  seg_len_q;
	logic [LEN_W-1:0]  seg_cnt_q;
	logic              enable_q;

	logic cfg_we;
	logic restart;
	cfg_t cfg;

	// front to queue to back
	logic q_push;
	logic q_full;
	op_t  q_in;
	logic q_pop;
	logic q_valid;
	op_t  q_out;

	// always taken and unchecked; the user sends register writes only while the block is idle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// any write to enable restarts playback from the ring start
	assign restart = cfg_we && (cfg_index == REG_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= RATE_RESET;
			seg_len_q     <= SEG_LEN_RESET;
			seg_cnt_q     <= SEG_CNT_RESET;
			enable_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_RATE: sample_rate_q <= cfg_data[RATE_W-1:0];
				REG_SEG_LEN:     seg_len_q     <= cfg_data[LEN_W-1:0];
				REG_SEG_CNT:     seg_cnt_q     <= cfg_data[LEN_W-1:0];
				REG_ENABLE:      enable_q      <= cfg_data[0];
				default: ;       // unknown index, write dropped
			endcase
		end
	end

	// length and count clamped to 1..4096; the raw length seeds a restart
	always_comb begin
		cfg.sample_rate = sample_rate_q;
		cfg.seg_len_raw = seg_len_q;
		cfg.seg_len     = clamp_len(seg_len_q);
		cfg.seg_cnt     = clamp_len(seg_cnt_q);
		cfg.enable      = enable_q;
	end

	prdac_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.enable   (cfg.enable),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	prdac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.valid     (q_valid)
	);

	prdac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.restart  (restart),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_data   (q_out),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* rtl/core/prdac_front.sv */
// ----------------------------------------------------------------------------
// prdac_front
// accepts input beats, unpacks them and drops ticks while playback is off
// ----------------------------------------------------------------------------
module prdac_front import prdac_pkg::*; (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 enable,
	input  logic                 q_full,
	output logic                 q_push,
	output op_t                  q_data
);

	logic accept;
	logic keep;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		q_data.func           = s_tuser;
		q_data.sample_address = s_tdata[ADDR_W-1:0];
		q_data.sample_value   = s_tdata[ADDR_W +: SAMPLE_W];
		q_data.elapsed_us     = s_tdata[ADDR_W + SAMPLE_W +: ELAPSED_W];
	end

	// sample writes always pass, ticks only while playing
	assign keep   = (s_tuser == FUNC_WRITE) || enable;
	assign q_push = accept && keep;

endmodule

/* rtl/core/prdac_queue.sv */
// ----------------------------------------------------------------------------
// prdac_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module prdac_queue import prdac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_data,
	output logic full,
	input  logic pop,
	output op_t  pop_data,
	output logic valid
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	op_t              slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/prdac_div.sv */
// ----------------------------------------------------------------------------
// prdac_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module prdac_div import prdac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DSR_W-1:0]  rmd_q;
	logic [DIV_W-1:0]  quo_q;

	logic [DSR_W:0] trial;
	logic [DSR_W:0] diff;
	logic           fits;

	// dividend comes left-aligned, its bits shift in from the top
	assign trial = {rmd_q, dvd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rmd  = rmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rmd_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			rmd_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

endmodule

/* rtl/core/prdac_back.sv */
// ----------------------------------------------------------------------------
// prdac_back
// sample ring, playback position and tick sequencer around a shared divider
// ----------------------------------------------------------------------------
module prdac_back import prdac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 restart,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  op_t                  q_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam logic [STEP_W-1:0] STEPS_SEG  = STEP_W'(POS_W);
	localparam logic [STEP_W-1:0] STEPS_SUM  = STEP_W'(SUM_W);
	localparam logic [STEP_W-1:0] STEPS_NEXT = STEP_W'(LIN_W);

	// 1000000 = 15625 << 6, so x / 1000000 = (x >> 6) / 15625; the reciprocal
	// below is exact for every 32-bit (x >> 6)
	localparam int                   US_SHIFT    = 6;
	localparam int                   RECIP_SHIFT = 45;
	localparam int                   QUO_W       = 2 * ELAPSED_W - RECIP_SHIFT;
	localparam logic [ELAPSED_W-1:0] RECIP_15625 = 32'd2251799814;   // ceil(2^45 / 15625)

	typedef enum logic [12:0] {
		S_IDLE       = 13'b0_0000_0000_0001,
		S_EL_QUO     = 13'b0_0000_0000_0010,
		S_EL_REM     = 13'b0_0000_0000_0100,
		S_MUL_REM    = 13'b0_0000_0000_1000,
		S_MUL_WHOLE  = 13'b0_0000_0001_0000,
		S_SC_QUO     = 13'b0_0000_0010_0000,
		S_SC_REM     = 13'b0_0000_0100_0000,
		S_DIV_SEG    = 13'b0_0000_1000_0000,
		S_START_LAST = 13'b0_0001_0000_0000,
		S_DIV_LAST   = 13'b0_0010_0000_0000,
		S_DIV_DONE   = 13'b0_0100_0000_0000,
		S_DIV_NEXT   = 13'b0_1000_0000_0000,
		S_EMIT       = 13'b1_0000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// playback state
	logic [FRAC_W-1:0] frac_q;
	logic [POS_W-1:0]  segnum_q;
	logic [LEN_W-1:0]  remain_q;

	// per-tick working registers
	logic [ELAPSED_W-1:0] el_q;
	logic [RING_W-1:0]    ring_q;
	logic [WHOLE_W-1:0]   whole_q;
	logic [FRAC_W-1:0]    rem_us_q;
	logic [DIV_W-1:0]     prod_q;
	logic [DIV_W-1:0]     scaled_q;
	logic [RATE_W-1:0]    sc_quo_q;     // samples due from the scaled remainder
	logic [DUE_W-1:0]     whole_sr_q;
	logic [DUE_W-1:0]     due_q;
	logic [POS_W-1:0]     pos_q;
	logic [LIN_W-1:0]     lin_q;
	logic [LIN_W-1:0]     next_q;
	logic [BYTE_W-1:0]    done_cnt_q;
	logic [POS_W-1:0]     pos_out_q;

	// ring memory
	logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [SAMPLE_W-1:0] rd_q;
	logic                mem_we;
	logic                mem_re;
	logic [RING_AW-1:0]  wr_addr;
	logic [RING_AW-1:0]  rd_addr;

	// output register
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic                 out_free;
	logic                 out_load;

	// shared reciprocal multiply for the two divisions by one million
	logic [ELAPSED_W-1:0]   recip_in;
	logic [2*ELAPSED_W-1:0] recip_prod;
	logic [QUO_W-1:0]       recip_quo;

	logic [DUE_W-1:0]  due_sum;
	logic [LEN_W-1:0]  rem_eff;
	logic [POS_W-1:0]  pos_new;
	logic [SUM_W-1:0]  last_num;
	logic [SUM_W-1:0]  done_num;
	logic [RING_W-1:0] last_plus;
	logic              is_tick;

	prdac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign is_tick = (q_data.func == FUNC_TICK);
	assign q_pop   = (state_q == S_IDLE) && q_valid;

	assign recip_in   = (state_q == S_EL_QUO) ? ELAPSED_W'(el_q[ELAPSED_W-1:US_SHIFT]) :
	                                            scaled_q[DIV_W-1:US_SHIFT];
	assign recip_prod = (2*ELAPSED_W)'(recip_in) * (2*ELAPSED_W)'(RECIP_15625);
	assign recip_quo  = recip_prod[2*ELAPSED_W-1:RECIP_SHIFT];

	assign due_sum = whole_sr_q + DUE_W'(sc_quo_q);
	// a stale count restarts the segment
	assign rem_eff = ((remain_q == '0) || (remain_q > cfg.seg_len)) ? cfg.seg_len : remain_q;
	assign pos_new = POS_W'(cfg.seg_len - rem_eff);

	assign last_num  = SUM_W'(lin_q) + SUM_W'(due_q) - SUM_W'(1);
	assign done_num  = SUM_W'(pos_q) + SUM_W'(due_q);
	assign last_plus = RING_W'(div_rsp.rmd) + RING_W'(1);

	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == S_EMIT) && out_free;

	assign mem_we  = q_pop && !is_tick;
	assign mem_re  = (state_q == S_DIV_LAST) && div_rsp.done;
	assign wr_addr = RING_AW'(q_data.sample_address);
	assign rd_addr = RING_AW'(div_rsp.rmd);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		state_d          = state_q;
		div_req          = '0;
		div_req.dividend = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid && is_tick) begin
					state_d = S_EL_QUO;
				end
			end
			S_EL_QUO: begin
				state_d = S_EL_REM;
			end
			S_EL_REM: begin
				state_d = S_MUL_REM;
			end
			S_MUL_REM: begin
				state_d = S_MUL_WHOLE;
			end
			S_MUL_WHOLE: begin
				state_d = S_SC_QUO;
			end
			S_SC_QUO: begin
				state_d = S_SC_REM;
			end
			S_SC_REM: begin
				if (due_sum == '0) begin
					state_d = S_IDLE;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(segnum_q) << (DIV_W - POS_W);
					div_req.divisor  = DSR_W'(cfg.seg_cnt);
					div_req.steps    = STEPS_SEG;
					state_d          = S_DIV_SEG;
				end
			end
			S_DIV_SEG: begin
				if (div_rsp.done) begin
					state_d = S_START_LAST;
				end
			end
			S_START_LAST: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(last_num) << (DIV_W - SUM_W);
				div_req.divisor  = DSR_W'(ring_q);
				div_req.steps    = STEPS_SUM;
				state_d          = S_DIV_LAST;
			end
			S_DIV_LAST: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(done_num) << (DIV_W - SUM_W);
					div_req.divisor  = DSR_W'(cfg.seg_len);
					div_req.steps    = STEPS_SUM;
					state_d          = S_DIV_DONE;
				end
			end
			S_DIV_DONE: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(next_q) << (DIV_W - LIN_W);
					div_req.divisor  = DSR_W'(cfg.seg_len);
					div_req.steps    = STEPS_NEXT;
					state_d          = S_DIV_NEXT;
				end
			end
			S_DIV_NEXT: begin
				if (div_rsp.done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wr_addr] <= q_data.sample_value;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frac_q      <= '0;
			segnum_q    <= '0;
			remain_q    <= SEG_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				frac_q   <= '0;
				segnum_q <= '0;
				remain_q <= cfg.seg_len_raw;
			end else begin
				// remainder of the scaled time, only its low bits matter
				if (state_q == S_SC_REM) begin
					frac_q <= scaled_q[FRAC_W-1:0] - FRAC_W'(sc_quo_q) * US_PER_SEC;
				end
				if ((state_q == S_DIV_NEXT) && div_rsp.done) begin
					segnum_q <= POS_W'(div_rsp.quo);
					remain_q <= cfg.seg_len - LEN_W'(div_rsp.rmd);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && is_tick) begin
			el_q   <= q_data.elapsed_us;
			ring_q <= RING_W'(cfg.seg_len) * RING_W'(cfg.seg_cnt);
		end
		if (state_q == S_EL_QUO) begin
			whole_q <= WHOLE_W'(recip_quo);
		end
		if (state_q == S_EL_REM) begin
			rem_us_q <= el_q[FRAC_W-1:0] - FRAC_W'(whole_q) * US_PER_SEC;
		end
		if (state_q == S_MUL_REM) begin
			prod_q <= DIV_W'(rem_us_q) * DIV_W'(cfg.sample_rate);
		end
		if (state_q == S_MUL_WHOLE) begin
			whole_sr_q <= DUE_W'(whole_q) * DUE_W'(cfg.sample_rate);
			scaled_q   <= DIV_W'(frac_q) + prod_q;
		end
		if (state_q == S_SC_QUO) begin
			sc_quo_q <= RATE_W'(recip_quo);
		end
		if (state_q == S_SC_REM) begin
			due_q <= due_sum;
			pos_q <= pos_new;
		end
		if ((state_q == S_DIV_SEG) && div_rsp.done) begin
			lin_q <= LIN_W'(POS_W'(div_rsp.rmd)) * LIN_W'(cfg.seg_len) + LIN_W'(pos_q);
		end
		if ((state_q == S_DIV_LAST) && div_rsp.done) begin
			next_q <= (last_plus == ring_q) ? '0 : LIN_W'(last_plus);
		end
		if ((state_q == S_DIV_DONE) && div_rsp.done) begin
			done_cnt_q <= (|div_rsp.quo[DIV_W-1:BYTE_W]) ? DONE_MAX : div_rsp.quo[BYTE_W-1:0];
		end
		if ((state_q == S_DIV_NEXT) && div_rsp.done) begin
			pos_out_q <= POS_W'(div_rsp.rmd);
		end
		if (out_load) begin
			out_data_q <= {
				(M_TDATA_W - POS_W - 2 * BYTE_W)'(0),
				pos_out_q,
				done_cnt_q,
				PSG_ATTEN_CMD | BYTE_W'(LEVEL_LUT[rd_q])
			};
		end
	end

endmodule

/* tb/pcm_ring_to_psg_attenuation_dac_top_tb.sv */
// ----------------------------------------------------------------------------
// pcm_ring_to_psg_attenuation_dac_top_tb
// self-checking bench for the ring-fed psg attenuation dac: sample writes and
// time ticks go in on the input stream, register setups change between phases,
// and every psg command that comes out is compared with the one predicted from
// the ring contents, the segment position and the time fraction
// ----------------------------------------------------------------------------
module pcm_ring_to_psg_attenuation_dac_top_tb;
	import prdac_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_BEATS = 1900;
	localparam int unsigned DRAIN_CYCLES = 400;     // covers up to three no-result ticks in flight
	localparam int unsigned LIMIT_CYCLES = 5000000;
	localparam int unsigned REPORT_MAX   = 10;
	localparam longint unsigned USEC     = 64'd1000000;
	localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(REG_ENABLE) + 1'b1;
	localparam logic [CFG_IDX_W-1:0] LAST_REG_CODE    = '1;

	// attenuation levels in units of 1/16 of a sample step, index 15 is silence
	localparam int unsigned ATTEN_STEPS [16] = '{
		32'h0ff0, 32'h0cb0, 32'h0a10, 32'h0800,
		32'h0650, 32'h0500, 32'h0400, 32'h0330,
		32'h0280, 32'h0200, 32'h0190, 32'h0140,
		32'h0100, 32'h00c0, 32'h00a0, 32'h0000
	};

	typedef struct packed {
		logic [BYTE_W-1:0] psg_byte;
		logic [BYTE_W-1:0] segs_done;
		logic [POS_W-1:0]  seg_pos;
	} psg_cmd_t;

	// ------------------------------------------------------------------------
	// playhead model and queue of psg commands still owed by the block
	// ------------------------------------------------------------------------
	class psg_cmd_board;
		logic [RATE_W-1:0]   rate        = RATE_RESET;
		logic [LEN_W-1:0]    seg_len_raw = SEG_LEN_RESET;
		logic [LEN_W-1:0]    seg_cnt_raw = SEG_CNT_RESET;
		bit                  enable      = 1'b0;
		longint unsigned     frac        = 0;
		longint unsigned     seg_num     = 0;
		longint unsigned     remaining   = longint'(SEG_LEN_RESET);
		logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
		bit                  written  [RING_DEPTH];
		psg_cmd_t            pending_cmds [$];
		int unsigned         errors = 0;

		function automatic longint unsigned clip_span(logic [LEN_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > 4096)
				return 4096;
			return longint'(v);
		endfunction

		// nearest attenuation step to the scaled sample, lowest index on a tie
		function automatic logic [LEVEL_W-1:0] atten_index(logic [SAMPLE_W-1:0] s);
			int unsigned goal;
			int unsigned gap;
			int unsigned best_gap;
			logic [LEVEL_W-1:0] best;
			goal     = (int'(s) * 32'h0ff0 + 127) / 255;
			best     = 4'd15;
			best_gap = '1;
			for (int i = 0; i < 16; i++) begin
				gap = (ATTEN_STEPS[i] > goal) ? ATTEN_STEPS[i] - goal : goal - ATTEN_STEPS[i];
				if (gap < best_gap) begin
					best_gap = gap;
					best     = LEVEL_W'(i);
				end
			end
			return best;
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SAMPLE_RATE: rate        = data[RATE_W-1:0];
				REG_SEG_LEN:     seg_len_raw = data[LEN_W-1:0];
				REG_SEG_CNT:     seg_cnt_raw = data[LEN_W-1:0];
				REG_ENABLE: begin
					enable    = data[0];
					frac      = 0;
					seg_num   = 0;
					remaining = longint'(seg_len_raw);
				end
				default: ;  // unused indexes are dropped
			endcase
		endfunction

		// moves the playhead for one tick; with commit low it only looks ahead
		// and reports which ring entry the tick would read
		function bit advance(input logic [ELAPSED_W-1:0] el, input bit commit,
				output psg_cmd_t cmd, output int unsigned rd_addr);
			longint unsigned scaled, due, len, cnt, span, rmn, pos, lin, last, nxt, done;
			cmd     = '0;
			rd_addr = 0;
			if (!enable)
				return 1'b0;
			scaled = frac + (longint'(el) % USEC) * longint'(rate);
			due    = (longint'(el) / USEC) * longint'(rate) + scaled / USEC;
			if (commit)
				frac = scaled % USEC;
			if (due == 0)
				return 1'b0;
			len  = clip_span(seg_len_raw);
			cnt  = clip_span(seg_cnt_raw);
			span = len * cnt;
			rmn  = remaining;
			// stale position after a length change restarts the segment
			if (rmn == 0 || rmn > len)
				rmn = len;
			pos  = len - rmn;
			lin  = ((seg_num % cnt) * len + pos) % span;
			last = (lin + due - 1) % span;
			nxt  = (lin + due) % span;
			done = (pos + due) / len;
			if (commit) begin
				seg_num   = nxt / len;
				remaining = len - nxt % len;
			end
			rd_addr       = int'(last % RING_DEPTH);
			cmd.psg_byte  = PSG_ATTEN_CMD | BYTE_W'(atten_index(ring_mem[rd_addr]));
			cmd.segs_done = (done > 255) ? DONE_MAX : BYTE_W'(done);
			cmd.seg_pos   = POS_W'(nxt % len);
			return 1'b1;
		endfunction

		function void note_beat(logic func, logic [ADDR_W-1:0] addr,
				logic [SAMPLE_W-1:0] value, logic [ELAPSED_W-1:0] el);
			psg_cmd_t cmd;
			int unsigned rd;
			if (func == FUNC_WRITE) begin
				ring_mem[addr] = value;
				written[addr]  = 1'b1;
			end else if (advance(el, 1'b1, cmd, rd)) begin
				pending_cmds.push_back(cmd);
			end
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= REPORT_MAX)
				$display("mismatch: %s", msg);
		endfunction

		function void check_beat(logic [M_TDATA_W-1:0] data);
			psg_cmd_t want;
			if (pending_cmds.size() == 0) begin
				flag($sformatf("result %h with none expected", data));
				return;
			end
			want = pending_cmds.pop_front();
			if (data[7:0] !== want.psg_byte || data[15:8] !== want.segs_done ||
					data[27:16] !== want.seg_pos)
				flag($sformatf("psg_byte exp %h got %h, segments exp %0d got %0d, pos exp %0d got %0d",
					want.psg_byte, data[7:0], want.segs_done, data[15:8],
					want.seg_pos, data[27:16]));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and block ports
	// ------------------------------------------------------------------------
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	psg_cmd_board board;
	int unsigned  cycle_count = 0;
	int unsigned  beats_sent  = 0;
	int unsigned  stall_left  = 0;
	bit           calm        = 1'b0;   // no idling on either side near the end
	bit           steady      = 1'b0;   // this phase sends without gaps

	always #5 clk = ~clk;

	pcm_ring_to_psg_attenuation_dac_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// result side: random stall bursts on m_tready, check on every beat
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_tready = 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 9);
			m_tready   = 1'b0;
		end else begin
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && m_tvalid && m_tready)
			board.check_beat(m_tdata);
	end

	// watchdog
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("pcm_ring_to_psg_attenuation_dac_top_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// drivers, all entered and left at a falling edge
	// ------------------------------------------------------------------------
	task automatic send_beat(input logic func, input logic [ADDR_W-1:0] addr,
			input logic [SAMPLE_W-1:0] value, input logic [ELAPSED_W-1:0] el);
		if (!calm && !steady && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = func;
		s_tdata  = S_TDATA_W'({el, value, addr});
		do @(posedge clk); while (!s_tready);
		// ticks dropped while disabled do not count as work
		if (func == FUNC_WRITE || board.enable)
			beats_sent++;
		board.note_beat(func, addr, value, el);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		board.apply_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// a tick that would read a ring entry never written gets that entry filled first
	task automatic play_tick(input logic [ELAPSED_W-1:0] el);
		psg_cmd_t    probe;
		int unsigned rd;
		if (board.advance(el, 1'b0, probe, rd) && !board.written[rd])
			send_beat(FUNC_WRITE, ADDR_W'(rd), SAMPLE_W'($urandom), $urandom);
		send_beat(FUNC_TICK, ADDR_W'($urandom), SAMPLE_W'($urandom), el);
	endtask

	// wait for every owed result, then for any no-result work still queued
	task automatic settle_block();
		while (board.pending_cmds.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [LEN_W-1:0] pick_span();
		case ($urandom_range(0, 9))
			0:          return '0;
			1:          return LEN_W'($urandom_range(4097, 8191));
			2:          return LEN_MAX;
			3, 4, 5, 6: return LEN_W'($urandom_range(1, 16));
			default:    return LEN_W'($urandom_range(1, 4096));
		endcase
	endfunction

	// new register setup for a phase; leaving enable unwritten keeps the old
	// position, so shrinking length or count hits the stale position paths
	task automatic shuffle_setup();
		logic [RATE_W-1:0] rate;
		case ($urandom_range(0, 19))
			0:       rate = '0;
			1:       rate = RATE_W'(1);
			2:       rate = RATE_W'(192000);
			3:       rate = RATE_W'($urandom_range(192001, 262143));
			4, 5:    rate = RATE_RESET;
			6, 7:    rate = RATE_W'(44100);
			default: rate = RATE_W'($urandom_range(1, 192000));
		endcase
		if ($urandom_range(0, 9) < 7)
			cfg_write(REG_SAMPLE_RATE, rate);
		if ($urandom_range(0, 9) < 7)
			cfg_write(REG_SEG_LEN, {5'($urandom), pick_span()});
		if ($urandom_range(0, 9) < 7)
			cfg_write(REG_SEG_CNT, {5'($urandom), pick_span()});
		if ($urandom_range(0, 4) == 0)
			cfg_write(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_CODE)),
				CFG_DATA_W'($urandom));
		if ($urandom_range(0, 9) < 8)
			cfg_write(REG_ENABLE, {17'($urandom), 1'($urandom_range(0, 9) != 0)});
		steady = ($urandom_range(0, 2) == 0);
	endtask

	task automatic random_beat();
		logic [ELAPSED_W-1:0] el;
		if ($urandom_range(0, 3) == 0) begin
			send_beat(FUNC_WRITE, ADDR_W'($urandom), SAMPLE_W'($urandom), $urandom);
		end else begin
			case ($urandom_range(0, 9))
				0:       el = $urandom_range(0, 3);
				1, 2, 3: el = $urandom_range(0, 300);
				4, 5:    el = $urandom_range(0, 20000);
				6:       el = $urandom_range(0, 2000000);
				7:       el = $urandom;
				default: el = $urandom_range(0, 1000);
			endcase
			play_tick(el);
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned rand_end;
		int unsigned calm_from;
		int unsigned phase_len;

		board = new;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset setup, playback off: fill entries with tie values and extremes
		send_beat(FUNC_WRITE, 12'h000, 8'd229, 32'hffff_ffff);   // tie between two steps
		send_beat(FUNC_WRITE, 12'h001, 8'd182, 32'h0000_0000);   // tie between two steps
		send_beat(FUNC_WRITE, 12'hfff, 8'hff, $urandom);
		send_beat(FUNC_WRITE, 12'h555, 8'h00, $urandom);
		play_tick(32'hffff_ffff);   // disabled tick gives nothing
		settle_block();

		// unused index is dropped, then play at reset rate and segments
		cfg_write(FIRST_UNUSED_REG, '1);
		cfg_write(REG_ENABLE, CFG_DATA_W'(1));
		play_tick(32'd0);           // nothing due
		play_tick(32'd62);          // nothing due, fraction builds up
		play_tick(32'd63);          // fraction carries into one sample
		play_tick(32'd125);
		play_tick(32'd1000000);     // several segments in one tick
		play_tick(32'hffff_ffff);   // full-width product, segment count saturates
		settle_block();

		// top rate, one-sample ring
		cfg_write(REG_SAMPLE_RATE, CFG_DATA_W'(192000));
		cfg_write(REG_SEG_LEN, CFG_DATA_W'(1));
		cfg_write(REG_SEG_CNT, CFG_DATA_W'(1));
		cfg_write(REG_ENABLE, CFG_DATA_W'(1));
		play_tick(32'd1);
		play_tick(32'd5);
		play_tick(32'd1000);
		settle_block();

		// zero rate never has anything due
		cfg_write(REG_SAMPLE_RATE, '0);
		cfg_write(REG_ENABLE, CFG_DATA_W'(1));
		play_tick(32'hffff_ffff);
		settle_block();

		// register extremes: length and count clamp to 1 and 4096
		cfg_write(REG_SAMPLE_RATE, '1);
		cfg_write(REG_SEG_LEN, '0);
		cfg_write(REG_SEG_CNT, CFG_DATA_W'(13'h1fff));
		cfg_write(REG_ENABLE, CFG_DATA_W'(1));
		play_tick(32'hffff_ffff);
		play_tick(32'd7);
		settle_block();

		// reshape the ring without restarting, then shrink the length under
		// the current position
		cfg_write(REG_SEG_LEN, CFG_DATA_W'(LEN_MAX));
		cfg_write(REG_SEG_CNT, CFG_DATA_W'(LEN_MAX));
		cfg_write(REG_SAMPLE_RATE, CFG_DATA_W'(44100));
		play_tick(32'd1000000);
		settle_block();
		cfg_write(REG_SEG_LEN, CFG_DATA_W'(3));
		play_tick(32'd100);

		// random phases, each with its own register setup
		rand_end  = beats_sent + RANDOM_BEATS;
		calm_from = beats_sent + RANDOM_BEATS * 85 / 100;
		while (beats_sent < rand_end) begin
			settle_block();
			shuffle_setup();
			phase_len = $urandom_range(80, 200);
			repeat (phase_len) begin
				if (beats_sent >= calm_from)
					calm = 1'b1;
				random_beat();
			end
		end

		// drain, then give stray results time to show up
		calm = 1'b1;
		while (board.pending_cmds.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (board.errors == 0)
			$display("pcm_ring_to_psg_attenuation_dac_top_tb: PASS");
		else
			$display("pcm_ring_to_psg_attenuation_dac_top_tb: FAIL");
		$finish;
	end

endmodule
